/* design/afk_pkg.sv */
// Package with payload types, constants and the arctangent table for the arm kinematics.
package afk_pkg;

    localparam int ANGLE_W = 16;
    localparam int POS_W   = 16;
    localparam int LEN_W   = 15;
    localparam int Q30_W   = 36;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [Q30_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [Q30_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [Q30_W-1:0] CORDIC_GAIN = 36'sd652032874;

    localparam logic [0:0] CFG_UPPER = 1'b0;
    localparam logic [0:0] CFG_LOWER = 1'b1;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] base_angle;
        logic signed [ANGLE_W-1:0] shoulder_angle;
        logic signed [ANGLE_W-1:0] elbow_angle;
    } afk_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] tip_x;
        logic signed [POS_W-1:0] tip_y;
        logic signed [POS_W-1:0] tip_z;
    } afk_out_t;

    // One CORDIC lane: residual angle, vector and the sign flip from range reduction.
    typedef struct packed {
        logic signed [Q30_W-1:0] ang;
        logic signed [Q30_W-1:0] x;
        logic signed [Q30_W-1:0] y;
        logic                    neg;
    } afk_lane_t;

    function automatic logic signed [Q30_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [Q30_W-1:0] v;
        unique case (i)
            5'd0:  v = 36'sh03243F6A8;
            5'd1:  v = 36'sh01DAC6705;
            5'd2:  v = 36'sh00FADBAFC;
            5'd3:  v = 36'sh007F56EA6;
            5'd4:  v = 36'sh003FEAB76;
            5'd5:  v = 36'sh001FFD55B;
            5'd6:  v = 36'sh000FFFAAA;
            5'd7:  v = 36'sh0007FFF55;
            5'd8:  v = 36'sh0003FFFEA;
            5'd9:  v = 36'sh0001FFFFD;
            5'd10: v = 36'sh0000FFFFF;
            5'd11: v = 36'sh00007FFFF;
            5'd12: v = 36'sh00003FFFF;
            5'd13: v = 36'sh00001FFFF;
            5'd14: v = 36'sh00000FFFF;
            5'd15: v = 36'sh000007FFF;
            5'd16: v = 36'sh000003FFF;
            5'd17: v = 36'sh000001FFF;
            5'd18: v = 36'sh000000FFF;
            5'd19: v = 36'sh0000007FF;
            5'd20: v = 36'sh0000003FF;
            5'd21: v = 36'sh0000001FF;
            5'd22: v = 36'sh0000000FF;
            5'd23: v = 36'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/afk_cordic_cell.sv */
// One CORDIC micro-rotation cell: three lanes turned by the same fixed step.
module afk_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                     aclk,
    input  logic                     advance,
    input  afk_pkg::afk_lane_t [2:0] lanes_in,
    output afk_pkg::afk_lane_t [2:0] lanes_out
);
    import afk_pkg::*;

    localparam logic signed [Q30_W-1:0] ATAN_STEP = atan_q30(5'(STEP));

    afk_lane_t [2:0] lanes_reg;
    afk_lane_t [2:0] lanes_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lanes_next[k].neg = lanes_in[k].neg;
            if (!lanes_in[k].ang[Q30_W-1]) begin
                lanes_next[k].x   = lanes_in[k].x - (lanes_in[k].y >>> STEP);
                lanes_next[k].y   = lanes_in[k].y + (lanes_in[k].x >>> STEP);
                lanes_next[k].ang = lanes_in[k].ang - ATAN_STEP;
            end else begin
                lanes_next[k].x   = lanes_in[k].x + (lanes_in[k].y >>> STEP);
                lanes_next[k].y   = lanes_in[k].y - (lanes_in[k].x >>> STEP);
                lanes_next[k].ang = lanes_in[k].ang + ATAN_STEP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lanes_reg <= lanes_next;
        end
    end

    assign lanes_out = lanes_reg;

endmodule

/* design/arm_forward_kinematics_3dof.sv */
// Top level of the three-joint arm forward kinematics pipeline.
// Input words carry base, shoulder and elbow angles in Q3.13 radians; each
// accepted word yields one result word with the tip position in Q2.14 metres,
// saturated. The pipeline is a range-reduction stage, a row of CORDIC_STEPS
// rotation cells and five arithmetic stages, CORDIC_STEPS + 6 register stages
// in all. Throughput is one word per cycle; every stage moves together.
// When the receiver stalls with m_ready low and the output register full, the
// whole pipeline holds, bubbles included, and s_ready drops; while the output
// register is empty new words keep entering. The configuration channel writes
// the two link lengths (index 0 upper, 1 lower) and is always ready; the user
// must make writes happen only while the block is idle, as the block itself
// does not enforce it. Synchronous active-low aresetn clears every valid bit
// and restores the default link lengths.
module arm_forward_kinematics_3dof #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  afk_pkg::afk_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output afk_pkg::afk_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import afk_pkg::*;

    localparam int DEPTH = CORDIC_STEPS + 6;

    logic [LEN_W-1:0] upper_len_reg;
    logic [LEN_W-1:0] lower_len_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             advance;

    // The pipeline moves whenever the last slot is empty or being taken.
    assign advance   = !valid_reg[DEPTH-1] || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = valid_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_len_reg <= LEN_W'(11469);
            lower_len_reg <= LEN_W'(11141);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_UPPER: upper_len_reg <= cfg_data[LEN_W-1:0];
                CFG_LOWER: lower_len_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_valid};
        end
    end

    // Stage 0: widen to Q.30 and reduce modulo pi; the shoulder plus elbow sum
    // reaches +-8, so at most three steps of pi are needed.
    function automatic afk_lane_t reduce(input logic signed [Q30_W-1:0] a_in);
        afk_lane_t r;
        logic signed [Q30_W-1:0] a;
        logic neg;
        a   = a_in;
        neg = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (a > Q30_HALF_PI) begin
                a   = a - Q30_PI;
                neg = !neg;
            end else if (a < -Q30_HALF_PI) begin
                a   = a + Q30_PI;
                neg = !neg;
            end
        end
        r.ang = a;
        r.x   = CORDIC_GAIN;
        r.y   = '0;
        r.neg = neg;
        return r;
    endfunction

    afk_lane_t [2:0] lanes_reg;
    logic signed [Q30_W-1:0] q1, q2, q23;

    always_comb begin
        q1  = Q30_W'(s_data.base_angle) <<< 17;
        q2  = Q30_W'(s_data.shoulder_angle) <<< 17;
        q23 = (Q30_W'(s_data.shoulder_angle) + Q30_W'(s_data.elbow_angle)) <<< 17;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lanes_reg[0] <= reduce(q1);
            lanes_reg[1] <= reduce(q2);
            lanes_reg[2] <= reduce(q23);
        end
    end

    afk_lane_t [2:0] chain [CORDIC_STEPS+1];
    assign chain[0] = lanes_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        afk_cordic_cell #(.STEP(g)) u_cell (
            .aclk      (aclk),
            .advance   (advance),
            .lanes_in  (chain[g]),
            .lanes_out (chain[g+1])
        );
    end

    // Apply the range-reduction sign flip.
    logic signed [Q30_W-1:0] c1_reg, s1_reg, c2_reg, s2_reg, c23_reg, s23_reg;
    afk_lane_t [2:0] fin;
    assign fin = chain[CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (advance) begin
            c1_reg  <= fin[0].neg ? -fin[0].x : fin[0].x;
            s1_reg  <= fin[0].neg ? -fin[0].y : fin[0].y;
            c2_reg  <= fin[1].neg ? -fin[1].x : fin[1].x;
            s2_reg  <= fin[1].neg ? -fin[1].y : fin[1].y;
            c23_reg <= fin[2].neg ? -fin[2].x : fin[2].x;
            s23_reg <= fin[2].neg ? -fin[2].y : fin[2].y;
        end
    end

    // Link-length products, Q.45.
    localparam int P_W = 53;
    logic signed [P_W-1:0] l2c_reg, l3c_reg, l2s_reg, l3s_reg;
    logic signed [Q30_W-1:0] c1_d_reg, s1_d_reg;
    logic signed [LEN_W:0] l2s, l3s;
    assign l2s = {1'b0, upper_len_reg};
    assign l3s = {1'b0, lower_len_reg};

    always_ff @(posedge aclk) begin
        if (advance) begin
            l2c_reg  <= P_W'(l2s) * P_W'(c2_reg);
            l3c_reg  <= P_W'(l3s) * P_W'(c23_reg);
            l2s_reg  <= P_W'(l2s) * P_W'(s2_reg);
            l3s_reg  <= P_W'(l3s) * P_W'(s23_reg);
            c1_d_reg <= c1_reg;
            s1_d_reg <= s1_reg;
        end
    end

    // Reach rounded to Q.30 and z sum.
    logic signed [P_W:0] reach45, z45;
    logic signed [P_W-15:0] reach30_reg;
    logic signed [P_W:0] z45_reg;
    logic signed [Q30_W-1:0] c1_e_reg, s1_e_reg;
    assign reach45 = (P_W+1)'(l2c_reg) + (P_W+1)'(l3c_reg) + (P_W+1)'(1 << 14);
    assign z45     = (P_W+1)'(l2s_reg) + (P_W+1)'(l3s_reg);

    always_ff @(posedge aclk) begin
        if (advance) begin
            reach30_reg <= reach45[P_W:15];
            z45_reg     <= z45;
            c1_e_reg    <= c1_d_reg;
            s1_e_reg    <= s1_d_reg;
        end
    end

    // Planar projection, Q.60 products. Sine and cosine fit in 32 signed bits
    // and the reach in 33, so the multipliers are only that wide.
    localparam int X_W = Q30_W + P_W - 14;
    logic signed [X_W-1:0] xp_reg, yp_reg;
    logic signed [P_W:0] z45_f_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            xp_reg    <= X_W'(signed'(c1_e_reg[31:0])) * X_W'(signed'(reach30_reg[32:0]));
            yp_reg    <= X_W'(signed'(s1_e_reg[31:0])) * X_W'(signed'(reach30_reg[32:0]));
            z45_f_reg <= z45_reg;
        end
    end

    function automatic logic signed [POS_W-1:0] sat(input logic signed [X_W-1:0] v);
        if (v > X_W'(32767)) begin
            return POS_W'(32767);
        end else if (v < -X_W'(32768)) begin
            return POS_W'(-32768);
        end
        return v[POS_W-1:0];
    endfunction

    logic signed [X_W-1:0] xr, yr, zr;
    logic signed [X_W-1:0] round45;
    assign round45 = X_W'(1) <<< 45;
    assign xr = (xp_reg + round45) >>> 46;
    assign yr = (yp_reg + round45) >>> 46;
    assign zr = (X_W'(z45_f_reg) + (X_W'(1) <<< 30)) >>> 31;

    afk_out_t out_reg;
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg.tip_x <= sat(xr);
            out_reg.tip_y <= sat(yr);
            out_reg.tip_z <= sat(zr);
        end
    end
    assign m_data = out_reg;

`ifndef SYNTHESIS
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed under stall");
    a_ready_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");
    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

/* sim/arm_forward_kinematics_3dof_checker.sv */
// Checker that predicts arm tip positions from observed joint words and compares them.
`timescale 1ns / 100ps
module arm_forward_kinematics_3dof_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  afk_pkg::afk_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  afk_pkg::afk_out_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output int                mismatches,
    output int                pending
);
    import afk_pkg::*;

    localparam int STEPS = 16;

    logic [LEN_W-1:0] upper_len;
    logic [LEN_W-1:0] lower_len;
    afk_out_t tip_queue[$];

    function automatic longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint tbl[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tbl[i];
    endfunction

    // Rotation-mode CORDIC after reducing the angle modulo pi.
    function automatic void rotate_q30(input longint ang, output longint c,
                                       output longint s);
        longint xv, yv, nx;
        bit flip;
        xv = 652032874;
        yv = 0;
        flip = 0;
        while (ang > 64'sd1686629713) begin
            ang -= 64'sd3373259426;
            flip = !flip;
        end
        while (ang < -64'sd1686629713) begin
            ang += 64'sd3373259426;
            flip = !flip;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (ang >= 0) begin
                nx = xv - floor_div(yv, i);
                yv = yv + floor_div(xv, i);
                ang -= atan_entry(i);
            end else begin
                nx = xv + floor_div(yv, i);
                yv = yv - floor_div(xv, i);
                ang += atan_entry(i);
            end
            xv = nx;
        end
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // The x and y products reach about 2^61, so they are formed at 128 bits.
    function automatic longint round_q60(longint a, longint b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b) + (128'sd1 <<< 45);
        p = p >>> 46;
        if (p > 40000) return 40000;
        if (p < -40000) return -40000;
        return longint'(p);
    endfunction

    function automatic afk_out_t tip_position(afk_in_t w, logic [LEN_W-1:0] l2,
                                              logic [LEN_W-1:0] l3);
        longint q1, q2, q3, c1, s1, c2, s2, c23, s23, reach45, z45, reach30;
        afk_out_t r;
        q1 = longint'(w.base_angle) * 131072;
        q2 = longint'(w.shoulder_angle) * 131072;
        q3 = longint'(w.elbow_angle) * 131072;
        rotate_q30(q1, c1, s1);
        rotate_q30(q2, c2, s2);
        rotate_q30(q2 + q3, c23, s23);
        reach45 = longint'(l2) * c2 + longint'(l3) * c23;
        z45 = longint'(l2) * s2 + longint'(l3) * s23;
        reach30 = (reach45 + (64'sd1 <<< 14)) >>> 15;
        r.tip_x = clamp16(round_q60(c1, reach30));
        r.tip_y = clamp16(round_q60(s1, reach30));
        r.tip_z = clamp16((z45 + (64'sd1 <<< 30)) >>> 31);
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("tip %s wrong: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    initial mismatches = 0;

    always @(posedge aclk) begin
        afk_out_t want;
        if (!aresetn) begin
            upper_len <= 15'd11469;
            lower_len <= 15'd11141;
            tip_queue.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_UPPER) upper_len <= cfg_data[14:0];
                else if (cfg_index == CFG_LOWER) lower_len <= cfg_data[14:0];
            end
            if (s_valid && s_ready)
                tip_queue.push_back(tip_position(s_data, upper_len, lower_len));
            if (m_valid && m_ready) begin
                if (tip_queue.size() == 0) begin
                    $display("unexpected result word at %0t", $realtime);
                    mismatches++;
                end else begin
                    want = tip_queue.pop_front();
                    if (m_data.tip_x !== want.tip_x) report("x", m_data.tip_x, want.tip_x);
                    if (m_data.tip_y !== want.tip_y) report("y", m_data.tip_y, want.tip_y);
                    if (m_data.tip_z !== want.tip_z) report("z", m_data.tip_z, want.tip_z);
                end
            end
            pending <= tip_queue.size();
        end
    end
endmodule

/* sim/arm_forward_kinematics_3dof_test.sv */
// Testbench top: drives joint words and link lengths into the arm kinematics block.
`timescale 1ns / 100ps
module arm_forward_kinematics_3dof_test;
    import afk_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    afk_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    afk_out_t m_data;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [0:0] cfg_index = CFG_UPPER;
    logic [15:0] cfg_data = '0;
    int mismatches, pending;
    int cycle_count = 0;
    bit hold_off = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    arm_forward_kinematics_3dof dut (.*);

    arm_forward_kinematics_3dof_checker checker_i (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 300000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls per word, plus a long hold-off on request.
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap = 0;
            repeat (gap) @(posedge aclk);
            while (hold_off) @(posedge aclk);
            m_ready <= 1;
            @(posedge aclk iff m_valid);
            m_ready <= 0;
        end
    end

    // Valid stays high after the accepting edge so that words can follow back
    // to back; it drops at the start of a gap or of a drain.
    task automatic send_word(afk_in_t w, int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= w;
        @(posedge aclk iff s_ready);
    endtask

    task automatic drain;
        s_valid <= 0;
        @(posedge aclk iff pending == 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_len(logic [0:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(0, 25736)) - 12868);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] edges[6] = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                                         16'sh3244, -16'sh3244, 16'sh6488};
        logic [15:0] lens[6] = '{16'hFFFF, 16'h0000, 16'h7FFF, 16'h2CCD, 16'h8001, 16'h4000};
        afk_in_t w;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed: extreme and quadrant-boundary angles at the default lengths.
        for (int i = 0; i < 6; i++) begin
            w.base_angle = edges[i];
            w.shoulder_angle = edges[(i + 1) % 6];
            w.elbow_angle = edges[(i + 3) % 6];
            send_word(w, 0);
        end
        for (int i = 0; i < 6; i++) begin
            w = '{edges[i], edges[i], edges[i]};
            send_word(w, 1);
        end
        drain();
        write_len(CFG_UPPER, 16'h7FFF);
        write_len(CFG_LOWER, 16'h7FFF);
        // Full-length links; the first and third of these words saturate the tip.
        send_word('{16'sh0000, 16'sh0000, 16'sh0000}, 0);
        send_word('{16'sh1922, 16'sh0000, 16'sh0000}, 0);
        send_word('{16'sh0000, 16'sh3244, 16'sh0000}, 0);
        send_word('{16'sh8000, -16'sh3244, 16'sh0000}, 0);
        // Long receiver stall while words keep coming.
        hold_off = 1;
        fork
            begin
                repeat (80) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 60; i++)
                send_word('{pick_angle(), pick_angle(), pick_angle()}, 0);
        join
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_len(CFG_UPPER, lens[ph]);
            write_len(CFG_LOWER, lens[(ph + 2) % 6]);
            for (int i = 0; i < 200; i++) begin
                w = '{pick_angle(), pick_angle(), pick_angle()};
                send_word(w, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8));
            end
        end
        drain();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* sim.f */
design/afk_pkg.sv
design/afk_cordic_cell.sv
design/arm_forward_kinematics_3dof.sv
sim/arm_forward_kinematics_3dof_checker.sv
sim/arm_forward_kinematics_3dof_test.sv
